>>> hdl/grammar_description_tokenizer_core_assert.svh
// Assertion helpers for the tokenizer core.
`ifndef GRAMMAR_DESCRIPTION_TOKENIZER_CORE_ASSERT_SVH
`define GRAMMAR_DESCRIPTION_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdt: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdt: next-cycle check failed");

`endif

>>> hdl/gdt_pkg.sv
package gdt_pkg;

    // result kinds
    localparam logic [1:0] KIND_NAME_CHAR = 2'd0;
    localparam logic [1:0] KIND_TOKEN     = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    // token classes
    localparam logic [2:0] CLS_NONTERM  = 3'd0;
    localparam logic [2:0] CLS_NUMERAL  = 3'd1;
    localparam logic [2:0] CLS_TERMINAL = 3'd2;
    localparam logic [2:0] CLS_EOI      = 3'd3;
    localparam logic [2:0] CLS_META     = 3'd4;

    // metasymbols
    localparam logic [2:0] META_COMMA  = 3'd0;
    localparam logic [2:0] META_PERIOD = 3'd1;
    localparam logic [2:0] META_EQUALS = 3'd2;
    localparam logic [2:0] META_CLOSE  = 3'd3;
    localparam logic [2:0] META_OPEN   = 3'd4;
    localparam logic [2:0] META_STAR   = 3'd5;

    // error codes
    localparam logic [1:0] ERR_BAD_CHAR     = 2'd0;
    localparam logic [1:0] ERR_EOI_IN_TERM  = 2'd1;
    localparam logic [1:0] ERR_NUM_TOO_LONG = 2'd2;

    // scanner modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_QUOTE = 3'd3;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_PERIOD     = 8'h2E;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_CLOSE      = 8'h5D;
    localparam logic [7:0] CH_OPEN       = 8'h5B;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_ZERO       = 8'h30;

    localparam logic [13:0] ACC_MAX = 14'h3FFF;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  token_class;
        logic [7:0]  char_value;
        logic [4:0]  char_index;
        logic [13:0] number_value;
        logic [2:0]  meta_symbol;
        logic [1:0]  error_code;
        logic        last_result;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h0C
            || c == 8'h0D || c == 8'h08;
    endfunction

    function automatic t_result mk_result(
        input logic [1:0]  kind,
        input logic [2:0]  cls,
        input logic [7:0]  ch,
        input logic [4:0]  idx,
        input logic [13:0] num,
        input logic [2:0]  meta,
        input logic [1:0]  err
    );
        t_result r;
        r.result_kind  = kind;
        r.token_class  = cls;
        r.char_value   = ch;
        r.char_index   = idx;
        r.number_value = num;
        r.meta_symbol  = meta;
        r.error_code   = err;
        r.last_result  = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/gdt_in_if.sv
interface gdt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

>>> hdl/gdt_out_if.sv
interface gdt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  token_class;
    logic [7:0]  char_value;
    logic [4:0]  char_index;
    logic [13:0] number_value;
    logic [2:0]  meta_symbol;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (
        output valid, output result_kind, output token_class, output char_value,
        output char_index, output number_value, output meta_symbol,
        output error_code, output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input token_class, input char_value,
        input char_index, input number_value, input meta_symbol,
        input error_code, input last_result, output ready
    );
endinterface

>>> hdl/grammar_description_tokenizer_core.sv
// Grammar-description tokenizer. Takes one byte (or end-of-input mark) per beat on i_in
// and emits name-character, token-complete and error beats on o_out. A byte is taken
// every cycle while the 4-entry result queue has at least two free slots; its results
// are in the queue in the cycle after acceptance. Most bytes give zero or one result; a
// byte that closes an identifier or numeral and itself yields a result gives two,
// both pushed into the queue together. After a fatal error, input beats are still taken
// but produce nothing until reset.
`include "grammar_description_tokenizer_core_assert.svh"

module grammar_description_tokenizer_core #(
    parameter int NAME_CHARS = 32,
    parameter int MAX_DIGITS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdt_in_if.sink    i_in,
    gdt_out_if.source o_out
);

    localparam int NCW = $clog2(NAME_CHARS + 1);
    localparam int DCW = $clog2(MAX_DIGITS + 2);

    logic [2:0]              r_mode, n_mode;
    logic [NCW-1:0]          r_name_count, n_name_count;
    logic [DCW-1:0]          r_digit_count, n_digit_count;
    logic [13:0]             r_acc, n_acc;
    logic                    r_err_stuck, n_err_stuck;

    gdt_pkg::t_result        r_q [gdt_pkg::Q_DEPTH];
    logic [gdt_pkg::QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [gdt_pkg::QCW-1:0] r_count;

    logic                    in_fire, out_fire;
    logic [7:0]              c;
    logic                    eoi;
    logic [3:0]              dval;
    logic [17:0]             acc_x10;

    // start-of-token decode
    logic                    st_valid, st_err;
    gdt_pkg::t_result        st_res;
    logic [2:0]              st_mode;
    logic [NCW-1:0]          st_name;

    gdt_pkg::t_result        res0, res1;
    logic [1:0]              nres, n_push;
    logic                    use_start;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign c        = i_in.byte_value;
    assign eoi      = i_in.end_of_input;
    assign dval     = 4'(c - gdt_pkg::CH_ZERO);
    assign acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 18'(dval);

    assign i_in.ready = (r_count <= gdt_pkg::QCW'(gdt_pkg::Q_DEPTH - 2));

    always_comb begin
        st_valid = 1'b0;
        st_err   = 1'b0;
        st_res   = '0;
        st_mode  = gdt_pkg::MODE_IDLE;
        st_name  = '0;
        if (eoi) begin
            st_valid = 1'b1;
            st_res   = gdt_pkg::mk_result(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_EOI,
                                          8'd0, 5'd0, 14'd0, 3'd0, 2'd0);
        end else if (gdt_pkg::is_space(c)) begin
            st_valid = 1'b0;
        end else if (gdt_pkg::is_letter(c)) begin
            st_valid = 1'b1;
            st_mode  = gdt_pkg::MODE_IDENT;
            st_name  = NCW'(1);
            st_res   = gdt_pkg::mk_result(gdt_pkg::KIND_NAME_CHAR, gdt_pkg::CLS_NONTERM,
                                          c, 5'd0, 14'd0, 3'd0, 2'd0);
        end else if (gdt_pkg::is_digit(c)) begin
            st_mode = gdt_pkg::MODE_NUM;
        end else if (c == gdt_pkg::CH_QUOTE) begin
            st_mode = gdt_pkg::MODE_QUOTE;
        end else begin
            st_valid = 1'b1;
            st_res   = gdt_pkg::mk_result(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_META,
                                          8'd0, 5'd0, 14'd0, 3'd0, 2'd0);
            unique case (c)
                gdt_pkg::CH_COMMA:  st_res.meta_symbol = gdt_pkg::META_COMMA;
                gdt_pkg::CH_PERIOD: st_res.meta_symbol = gdt_pkg::META_PERIOD;
                gdt_pkg::CH_EQUALS: st_res.meta_symbol = gdt_pkg::META_EQUALS;
                gdt_pkg::CH_CLOSE:  st_res.meta_symbol = gdt_pkg::META_CLOSE;
                gdt_pkg::CH_OPEN:   st_res.meta_symbol = gdt_pkg::META_OPEN;
                gdt_pkg::CH_STAR:   st_res.meta_symbol = gdt_pkg::META_STAR;
                default: begin
                    st_err = 1'b1;
                    st_res = gdt_pkg::mk_result(gdt_pkg::KIND_ERROR, gdt_pkg::CLS_NONTERM,
                                                8'd0, 5'd0, 14'd0, 3'd0,
                                                gdt_pkg::ERR_BAD_CHAR);
                end
            endcase
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_name_count  = r_name_count;
        n_digit_count = r_digit_count;
        n_acc         = r_acc;
        n_err_stuck   = r_err_stuck;
        res0          = '0;
        res1          = '0;
        nres          = 2'd0;
        use_start     = 1'b0;

        if (!r_err_stuck) begin
            unique case (r_mode)
                gdt_pkg::MODE_IDENT: begin
                    if (!eoi && (gdt_pkg::is_letter(c) || gdt_pkg::is_digit(c)
                                 || c == gdt_pkg::CH_UNDERSCORE)) begin
                        if (r_name_count < NCW'(NAME_CHARS)) begin
                            res0 = gdt_pkg::mk_result(gdt_pkg::KIND_NAME_CHAR,
                                                      gdt_pkg::CLS_NONTERM, c,
                                                      5'(r_name_count), 14'd0, 3'd0, 2'd0);
                            nres = 2'd1;
                            n_name_count = r_name_count + NCW'(1);
                        end
                    end else begin
                        res0 = gdt_pkg::mk_result(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_NONTERM,
                                                  8'd0, 5'd0, 14'd0, 3'd0, 2'd0);
                        nres      = 2'd1;
                        use_start = 1'b1;
                    end
                end
                gdt_pkg::MODE_NUM: begin
                    if (!eoi && gdt_pkg::is_digit(c)) begin
                        if (r_digit_count <= DCW'(MAX_DIGITS))
                            n_digit_count = r_digit_count + DCW'(1);
                        n_acc = (acc_x10 > 18'(gdt_pkg::ACC_MAX)) ? gdt_pkg::ACC_MAX
                                                                 : acc_x10[13:0];
                    end else if (r_digit_count > DCW'(MAX_DIGITS)) begin
                        // too many digits: error replaces the token, terminator dropped
                        res0 = gdt_pkg::mk_result(gdt_pkg::KIND_ERROR, gdt_pkg::CLS_NONTERM,
                                                  8'd0, 5'd0, 14'd0, 3'd0,
                                                  gdt_pkg::ERR_NUM_TOO_LONG);
                        nres        = 2'd1;
                        n_err_stuck = 1'b1;
                        n_mode      = gdt_pkg::MODE_IDLE;
                    end else begin
                        res0 = gdt_pkg::mk_result(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_NUMERAL,
                                                  8'd0, 5'd0, r_acc, 3'd0, 2'd0);
                        nres      = 2'd1;
                        use_start = 1'b1;
                    end
                end
                gdt_pkg::MODE_QUOTE: begin
                    if (eoi) begin
                        res0 = gdt_pkg::mk_result(gdt_pkg::KIND_ERROR, gdt_pkg::CLS_NONTERM,
                                                  8'd0, 5'd0, 14'd0, 3'd0,
                                                  gdt_pkg::ERR_EOI_IN_TERM);
                        nres        = 2'd1;
                        n_err_stuck = 1'b1;
                        n_mode      = gdt_pkg::MODE_IDLE;
                    end else if (c != gdt_pkg::CH_QUOTE || r_name_count == '0) begin
                        // first char after the opening quote is literal, quote or not
                        if (r_name_count < NCW'(NAME_CHARS)) begin
                            res0 = gdt_pkg::mk_result(gdt_pkg::KIND_NAME_CHAR,
                                                      gdt_pkg::CLS_TERMINAL, c,
                                                      5'(r_name_count), 14'd0, 3'd0, 2'd0);
                            nres = 2'd1;
                            n_name_count = r_name_count + NCW'(1);
                        end
                    end else begin
                        res0 = gdt_pkg::mk_result(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_TERMINAL,
                                                  8'd0, 5'd0, 14'd0, 3'd0, 2'd0);
                        nres   = 2'd1;
                        n_mode = gdt_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    use_start = 1'b1;
                end
            endcase

            if (use_start) begin
                n_mode        = st_err ? gdt_pkg::MODE_IDLE : st_mode;
                n_name_count  = st_name;
                n_digit_count = DCW'(1);
                n_acc         = 14'(dval);
                n_err_stuck   = st_err;
                if (st_valid) begin
                    if (nres == 2'd0) begin
                        res0 = st_res;
                        nres = 2'd1;
                    end else begin
                        res1 = st_res;
                        nres = 2'd2;
                    end
                end
            end

            if (nres == 2'd2)
                res1.last_result = 1'b1;
            else
                res0.last_result = 1'b1;
        end
    end

    assign n_push = in_fire ? nres : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= gdt_pkg::MODE_IDLE;
            r_name_count  <= '0;
            r_digit_count <= '0;
            r_acc         <= '0;
            r_err_stuck   <= 1'b0;
        end else if (in_fire) begin
            r_mode        <= n_mode;
            r_name_count  <= n_name_count;
            r_digit_count <= n_digit_count;
            r_acc         <= n_acc;
            r_err_stuck   <= n_err_stuck;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + gdt_pkg::QAW'(n_push);
            if (out_fire)
                r_rd_ptr <= r_rd_ptr + gdt_pkg::QAW'(1);
            r_count <= r_count + gdt_pkg::QCW'(n_push) - gdt_pkg::QCW'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0)
            r_q[r_wr_ptr] <= res0;
        if (n_push == 2'd2)
            r_q[r_wr_ptr + gdt_pkg::QAW'(1)] <= res1;
    end

    assign o_out.valid        = (r_count != '0);
    assign o_out.result_kind  = r_q[r_rd_ptr].result_kind;
    assign o_out.token_class  = r_q[r_rd_ptr].token_class;
    assign o_out.char_value   = r_q[r_rd_ptr].char_value;
    assign o_out.char_index   = r_q[r_rd_ptr].char_index;
    assign o_out.number_value = r_q[r_rd_ptr].number_value;
    assign o_out.meta_symbol  = r_q[r_rd_ptr].meta_symbol;
    assign o_out.error_code   = r_q[r_rd_ptr].error_code;
    assign o_out.last_result  = r_q[r_rd_ptr].last_result;

    `GDT_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err_stuck, r_err_stuck)
    `GDT_ASSERT_NOW(a_silent_after_err, i_clk, i_rst_n, r_err_stuck, n_push == 2'd0)
    `GDT_ASSERT_NOW(a_queue_room, i_clk, i_rst_n, in_fire,
                    (r_count + gdt_pkg::QCW'(n_push)) <= gdt_pkg::QCW'(gdt_pkg::Q_DEPTH))

endmodule

>>> dv/grammar_description_tokenizer_core_test.sv
module grammar_description_tokenizer_core_test;

    localparam int NAME_CHARS  = 32;
    localparam int MAX_DIGITS  = 4;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    gdt_in_if  byte_ch();
    gdt_out_if token_ch();

    grammar_description_tokenizer_core #(
        .NAME_CHARS(NAME_CHARS),
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (token_ch)
    );

    logic [7:0] blank_chars [6] = '{8'h20, 8'h0A, 8'h09, 8'h0C, 8'h0D, 8'h08};
    logic [7:0] meta_chars  [6] = '{gdt_pkg::CH_COMMA, gdt_pkg::CH_PERIOD,
                                    gdt_pkg::CH_EQUALS, gdt_pkg::CH_CLOSE,
                                    gdt_pkg::CH_OPEN, gdt_pkg::CH_STAR};

    // predicted scanner state
    logic [2:0] scan_state    = gdt_pkg::MODE_IDLE;
    int         name_len      = 0;
    int         digit_len     = 0;
    int         numeral_acc   = 0;
    bit         error_latched = 1'b0;

    gdt_pkg::t_result awaited_results[$];
    gdt_pkg::t_result step_results[$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int bytes_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    bit numeral_open   = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c inside {8'h20, 8'h0A, 8'h09, 8'h0C, 8'h0D, 8'h08};
    endfunction

    function automatic void emit(logic [1:0] kind, logic [2:0] cls, logic [7:0] ch,
                                 logic [4:0] idx, logic [13:0] num, logic [2:0] meta,
                                 logic [1:0] err);
        gdt_pkg::t_result r;
        r.result_kind  = kind;
        r.token_class  = cls;
        r.char_value   = ch;
        r.char_index   = idx;
        r.number_value = num;
        r.meta_symbol  = meta;
        r.error_code   = err;
        r.last_result  = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void take_char(logic [2:0] cls, logic [7:0] c);
        if (name_len < NAME_CHARS) begin
            emit(gdt_pkg::KIND_NAME_CHAR, cls, c, 5'(name_len), '0, '0, '0);
            name_len++;
        end
    endfunction

    function automatic void raise_fault(logic [1:0] code);
        emit(gdt_pkg::KIND_ERROR, gdt_pkg::CLS_NONTERM, '0, '0, '0, '0, code);
        error_latched = 1'b1;
        scan_state    = gdt_pkg::MODE_IDLE;
    endfunction

    function automatic void begin_token(logic [7:0] c, logic eoi);
        logic [2:0] meta;
        bit         known;
        known = 1'b1;
        meta  = gdt_pkg::META_COMMA;
        if (eoi) begin
            emit(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_EOI, '0, '0, '0, '0, '0);
        end else if (is_alpha(c)) begin
            scan_state = gdt_pkg::MODE_IDENT;
            name_len   = 0;
            take_char(gdt_pkg::CLS_NONTERM, c);
        end else if (is_num(c)) begin
            scan_state  = gdt_pkg::MODE_NUM;
            digit_len   = 1;
            numeral_acc = c - gdt_pkg::CH_ZERO;
        end else if (c == gdt_pkg::CH_QUOTE) begin
            scan_state = gdt_pkg::MODE_QUOTE;
            name_len   = 0;
        end else if (!is_blank(c)) begin
            case (c)
                gdt_pkg::CH_COMMA:  meta = gdt_pkg::META_COMMA;
                gdt_pkg::CH_PERIOD: meta = gdt_pkg::META_PERIOD;
                gdt_pkg::CH_EQUALS: meta = gdt_pkg::META_EQUALS;
                gdt_pkg::CH_CLOSE:  meta = gdt_pkg::META_CLOSE;
                gdt_pkg::CH_OPEN:   meta = gdt_pkg::META_OPEN;
                gdt_pkg::CH_STAR:   meta = gdt_pkg::META_STAR;
                default:            known = 1'b0;
            endcase
            if (known)
                emit(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_META, '0, '0, '0, meta, '0);
            else
                raise_fault(gdt_pkg::ERR_BAD_CHAR);
        end
    endfunction

    // works out the result beats that one accepted byte causes
    function automatic void scan_byte(logic [7:0] c, logic eoi);
        step_results.delete();
        if (!error_latched) begin
            case (scan_state)
                gdt_pkg::MODE_IDENT: begin
                    if (!eoi && (is_alpha(c) || is_num(c)
                                 || c == gdt_pkg::CH_UNDERSCORE)) begin
                        take_char(gdt_pkg::CLS_NONTERM, c);
                    end else begin
                        emit(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_NONTERM,
                             '0, '0, '0, '0, '0);
                        scan_state = gdt_pkg::MODE_IDLE;
                        begin_token(c, eoi);
                    end
                end
                gdt_pkg::MODE_NUM: begin
                    if (!eoi && is_num(c)) begin
                        if (digit_len <= MAX_DIGITS)
                            digit_len++;
                        numeral_acc = numeral_acc * 10 + (c - gdt_pkg::CH_ZERO);
                        if (numeral_acc > gdt_pkg::ACC_MAX)
                            numeral_acc = gdt_pkg::ACC_MAX;
                    end else if (digit_len > MAX_DIGITS) begin
                        // terminating byte is dropped here
                        raise_fault(gdt_pkg::ERR_NUM_TOO_LONG);
                    end else begin
                        emit(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_NUMERAL, '0, '0,
                             14'(numeral_acc), '0, '0);
                        scan_state = gdt_pkg::MODE_IDLE;
                        begin_token(c, eoi);
                    end
                end
                gdt_pkg::MODE_QUOTE: begin
                    if (eoi) begin
                        raise_fault(gdt_pkg::ERR_EOI_IN_TERM);
                    end else if (c != gdt_pkg::CH_QUOTE || name_len == 0) begin
                        // first char after the opening quote is literal, even a quote
                        take_char(gdt_pkg::CLS_TERMINAL, c);
                        if (name_len == 0)
                            name_len = 1;
                    end else begin
                        emit(gdt_pkg::KIND_TOKEN, gdt_pkg::CLS_TERMINAL,
                             '0, '0, '0, '0, '0);
                        scan_state = gdt_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    scan_state = gdt_pkg::MODE_IDLE;
                    begin_token(c, eoi);
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_result = 1'b1;
        foreach (step_results[i])
            awaited_results.push_back(step_results[i]);
    endfunction

    function automatic string show(gdt_pkg::t_result r);
        return $sformatf("kind=%0d class=%0d char=%02h idx=%0d num=%0d meta=%0d err=%0d last=%0b",
                         r.result_kind, r.token_class, r.char_value, r.char_index,
                         r.number_value, r.meta_symbol, r.error_code, r.last_result);
    endfunction

    function automatic void note_fault(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endfunction

    always @(posedge clk) begin
        token_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, awaited_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        gdt_pkg::t_result got;
        gdt_pkg::t_result want;
        if (rst_n && token_ch.valid && token_ch.ready) begin
            got.result_kind  = token_ch.result_kind;
            got.token_class  = token_ch.token_class;
            got.char_value   = token_ch.char_value;
            got.char_index   = token_ch.char_index;
            got.number_value = token_ch.number_value;
            got.meta_symbol  = token_ch.meta_symbol;
            got.error_code   = token_ch.error_code;
            got.last_result  = token_ch.last_result;
            if (awaited_results.size() == 0) begin
                note_fault({"unexpected beat: ", show(got)});
            end else begin
                want = awaited_results.pop_front();
                if (got.result_kind !== want.result_kind
                        || got.token_class !== want.token_class
                        || got.char_value !== want.char_value
                        || got.char_index !== want.char_index
                        || got.number_value !== want.number_value
                        || got.meta_symbol !== want.meta_symbol
                        || got.error_code !== want.error_code
                        || got.last_result !== want.last_result)
                    note_fault({"expected ", show(want), " got ", show(got)});
            end
        end
    end

    task automatic send_item(logic [7:0] b, logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid        <= 1'b0;
            byte_ch.byte_value   <= 8'($urandom);
            byte_ch.end_of_input <= 1'($urandom);
            @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_value   <= b;
        byte_ch.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        scan_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(25));
    endfunction

    function automatic int name_length();
        return ($urandom_range(15) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
    endfunction

    task automatic wait_drain();
        byte_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // one well-formed token with random content or a run of blanks, sometimes preceded by a blank
    task automatic send_token();
        int         pick;
        int         len;
        int         style;
        logic [7:0] c;
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0 || (numeral_open && pick >= 28 && pick < 46))
            send_item(blank_chars[$urandom_range(5)], 1'b0);
        numeral_open = 1'b0;
        if (pick < 28) begin
            send_item(rand_letter(), 1'b0);
            len = name_length();
            repeat (len) begin
                style = $urandom_range(62);
                if (style < 52)
                    c = rand_letter();
                else if (style < 62)
                    c = gdt_pkg::CH_ZERO + 8'($urandom_range(9));
                else
                    c = gdt_pkg::CH_UNDERSCORE;
                send_item(c, 1'b0);
            end
        end else if (pick < 46) begin
            style = $urandom_range(7);
            len   = (style < 2) ? MAX_DIGITS : $urandom_range(1, MAX_DIGITS);
            repeat (len) begin
                if (style == 0)
                    c = gdt_pkg::CH_ZERO + 8'd9;
                else if (style == 1)
                    c = gdt_pkg::CH_ZERO;
                else
                    c = gdt_pkg::CH_ZERO + 8'($urandom_range(9));
                send_item(c, 1'b0);
            end
            numeral_open = 1'b1;
        end else if (pick < 64) begin
            send_item(gdt_pkg::CH_QUOTE, 1'b0);
            send_item(($urandom_range(7) == 0) ? gdt_pkg::CH_QUOTE
                                               : 8'($urandom_range(255)), 1'b0);
            len = name_length();
            repeat (len) begin
                do
                    c = 8'($urandom_range(255));
                while (c == gdt_pkg::CH_QUOTE);
                send_item(c, 1'b0);
            end
            send_item(gdt_pkg::CH_QUOTE, 1'b0);
        end else if (pick < 86) begin
            send_item(meta_chars[$urandom_range(5)], 1'b0);
        end else if (pick < 93) begin
            send_item(8'($urandom), 1'b1);
        end else begin
            len = $urandom_range(1, 5);
            repeat (len)
                send_item(blank_chars[$urandom_range(5)], 1'b0);
        end
    endtask

    task automatic run_phase(int idle_pct, int hold_pct, int count);
        int target;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        target        = bytes_sent + count;
        while (bytes_sent < target)
            send_token();
        wait_drain();
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_text("a_9,");
        send_text("9999 ");
        send_text("0=");
        send_text("'''");
        send_text(".][*");
        foreach (blank_chars[i])
            send_item(blank_chars[i], 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_free_flow();
        run_phase(0, 0, 200);
    endtask

    task automatic test_sender_gaps();
        run_phase(85, 0, 200);
    endtask

    task automatic test_receiver_stalls();
        run_phase(0, 85, 200);
    endtask

    task automatic test_both_idle();
        run_phase(38, 38, 200);
    endtask

    // only one fatal error fits in a run; the seed picks which
    task automatic test_sticky_error();
        int         which;
        int         len;
        logic [7:0] c;
        send_idle_pct = 20;
        stall_pct     = 20;
        which         = $urandom_range(2);
        send_item(8'h20, 1'b0);
        if (which == 0) begin
            do
                c = 8'($urandom_range(255));
            while (is_alpha(c) || is_num(c) || is_blank(c) || c == gdt_pkg::CH_QUOTE
                   || c inside {gdt_pkg::CH_COMMA, gdt_pkg::CH_PERIOD,
                                gdt_pkg::CH_EQUALS, gdt_pkg::CH_CLOSE,
                                gdt_pkg::CH_OPEN, gdt_pkg::CH_STAR});
            send_item(c, 1'b0);
        end else if (which == 1) begin
            send_item(gdt_pkg::CH_QUOTE, 1'b0);
            send_item(8'($urandom_range(255)), 1'b0);
            send_item(8'($urandom), 1'b1);
        end else begin
            len = $urandom_range(MAX_DIGITS + 1, 9);
            repeat (len)
                send_item(gdt_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
            case ($urandom_range(2))
                0:       send_item(blank_chars[$urandom_range(5)], 1'b0);
                1:       send_item(rand_letter(), 1'b0);
                default: send_item(8'($urandom), 1'b1);
            endcase
        end
        // everything after the error must stay silent
        repeat (20)
            send_token();
        wait_drain();
    endtask

    initial begin
        rst_n                <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.byte_value   <= 8'h00;
        byte_ch.end_of_input <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_free_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_sticky_error();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
